### hw/rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// shared types and constants of the quadratic root solver
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  localparam int VALUE_W = 40;

  typedef enum logic [1:0] {
    KIND_REAL    = 2'd0,
    KIND_REPEAT  = 2'd1,
    KIND_COMPLEX = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

endpackage

`default_nettype wire

### hw/rtl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// roots of a*x^2 + b*x + c in signed fixed point, fully pipelined
// ----------------------------------------------------------------------------
// A coefficient set (coef_a, coef_b, coef_c) transfers on in_valid & in_ready;
// one result (root_kind, first_value, second_value) transfers on
// out_valid & out_ready. Kind 0 gives two real roots, kind 1 the repeated
// root twice, kind 2 the real and imaginary parts, kind 3 flags a = 0 with
// zero values. Values carry FRAC_BITS fractional bits.
// The square root is a chain of NS = COEF_WIDTH + FRAC_BITS + 1 cells and the
// divider a chain of NQ = COEF_WIDTH + FRAC_BITS + 2 cells, all one-digit
// cells, each of which holds one set at a time. One set enters every cycle
// while the receiver keeps out_ready high and so does not stall the output.
// Each stage moves forward when it is empty or its successor moves, so a
// stalled receiver only holds the full stages in front of it and the
// pipeline keeps taking items until it is full. Reset clears all stage valid
// bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver import qrs_pkg::*; #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COEF_WIDTH-1:0] coef_a,
  input  wire logic signed [COEF_WIDTH-1:0] coef_b,
  input  wire logic signed [COEF_WIDTH-1:0] coef_c,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic             [1:0]            root_kind,
  output logic signed      [VALUE_W-1:0]    first_value,
  output logic signed      [VALUE_W-1:0]    second_value
);

  localparam int CW  = COEF_WIDTH;
  localparam int DW  = 2 * CW + 2;
  localparam int NS  = (DW + 2 * FRAC_BITS + 1) / 2;
  localparam int RW  = 2 * NS;
  localparam int NQ  = CW + FRAC_BITS + 2;
  localparam int VW  = CW + 1;
  localparam int STW = 2 + 1 + (NQ + 1) + VW;
  localparam int DTW = 4;
  localparam int NST = NS + NQ + 4;
  localparam int QX  = (NQ > VALUE_W) ? NQ : VALUE_W;
  localparam logic [QX-1:0] LIM = QX'(1) << (VALUE_W - 1);

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          v[i] <= (i == 0) ? in_valid : v[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // products
  logic [CW-1:0]   a_mag, b_mag, c_mag;
  logic [2*CW-1:0] s0_bb, s0_ac;
  logic            s0_pos_ac, s0_az, s0_aneg;
  logic [CW-1:0]   s0_b, s0_amag;

  assign a_mag = coef_a[CW-1] ? (~coef_a + 1'b1) : coef_a;
  assign b_mag = coef_b[CW-1] ? (~coef_b + 1'b1) : coef_b;
  assign c_mag = coef_c[CW-1] ? (~coef_c + 1'b1) : coef_c;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_bb     <= (2*CW)'(b_mag) * (2*CW)'(b_mag);
      s0_ac     <= (2*CW)'(a_mag) * (2*CW)'(c_mag);
      s0_pos_ac <= (coef_a[CW-1] == coef_c[CW-1]) && (coef_c != '0);
      s0_az     <= (coef_a == '0);
      s0_aneg   <= coef_a[CW-1];
      s0_b      <= coef_b;
      s0_amag   <= a_mag;
    end
  end

  // discriminant and classification
  logic [DW-1:0] bbx, fac, dmag;
  logic          dneg;
  kind_t         kind1;
  logic [NQ:0]   b_ext, nb1;

  always_comb begin
    bbx  = DW'(s0_bb);
    fac  = DW'(s0_ac) << 2;
    dneg = 1'b0;
    if (s0_pos_ac) begin
      if (bbx >= fac) begin
        dmag = bbx - fac;
      end else begin
        dmag = fac - bbx;
        dneg = 1'b1;
      end
    end else begin
      dmag = bbx + fac;
    end
    if (s0_az) begin
      kind1 = KIND_INVALID;
    end else if (dneg) begin
      kind1 = KIND_COMPLEX;
    end else if (dmag == '0) begin
      kind1 = KIND_REPEAT;
    end else begin
      kind1 = KIND_REAL;
    end
    b_ext = {{(NQ + 1 - CW){s0_b[CW-1]}}, s0_b};
    nb1   = (~b_ext + 1'b1) << FRAC_BITS;
  end

  logic [RW-1:0]  sq_rad  [0:NS];
  logic [NS+1:0]  sq_rem  [0:NS];
  logic [NS-1:0]  sq_root [0:NS];
  logic [STW-1:0] sq_tag  [0:NS];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sq_rad[0]  <= RW'(dmag) << (2 * FRAC_BITS);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_tag[0]  <= {kind1, s0_aneg, nb1, s0_amag, 1'b0};
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    qrs_sqrt_cell #(.NS(NS), .TW(STW)) u_cell (
      .clk      (clk),
      .en       (en[2+k]),
      .rad_in   (sq_rad[k]),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .tag_in   (sq_tag[k]),
      .rad_out  (sq_rad[k+1]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1]),
      .tag_out  (sq_tag[k+1])
    );
  end

  // numerators
  kind_t         kind2;
  logic          aneg2;
  logic [NQ:0]   nb2, sx, n1, n2, m1, m2;
  logic [VW-1:0] d2;

  always_comb begin
    kind2 = kind_t'(sq_tag[NS][STW-1 -: 2]);
    aneg2 = sq_tag[NS][STW-3];
    nb2   = sq_tag[NS][VW +: NQ + 1];
    d2    = sq_tag[NS][VW-1:0];
    sx    = (NQ + 1)'(sq_root[NS]);
    case (kind2)
      KIND_REAL: begin
        n1 = nb2 + sx;
        n2 = nb2 - sx;
      end
      KIND_REPEAT: begin
        n1 = nb2;
        n2 = nb2;
      end
      KIND_COMPLEX: begin
        n1 = nb2;
        n2 = sx;
      end
      default: begin
        n1 = '0;
        n2 = '0;
      end
    endcase
    m1 = n1[NQ] ? (~n1 + 1'b1) : n1;
    m2 = n2[NQ] ? (~n2 + 1'b1) : n2;
  end

  logic [VW-1:0]  dv_d   [0:NQ];
  logic [NQ-1:0]  dv_n1  [0:NQ];
  logic [VW-1:0]  dv_r1  [0:NQ];
  logic [NQ-1:0]  dv_n2  [0:NQ];
  logic [VW-1:0]  dv_r2  [0:NQ];
  logic [DTW-1:0] dv_tag [0:NQ];

  always_ff @(posedge clk) begin
    if (en[2+NS]) begin
      dv_d[0]   <= d2;
      dv_n1[0]  <= m1[NQ-1:0];
      dv_n2[0]  <= m2[NQ-1:0];
      dv_r1[0]  <= '0;
      dv_r2[0]  <= '0;
      dv_tag[0] <= {kind2, n1[NQ] ^ aneg2, n2[NQ] ^ aneg2};
    end
  end

  for (genvar j = 0; j < NQ; j++) begin : g_div
    qrs_div_cell #(.NQ(NQ), .DW(VW), .TW(DTW)) u_cell (
      .clk     (clk),
      .en      (en[3+NS+j]),
      .d_in    (dv_d[j]),
      .n1_in   (dv_n1[j]),
      .r1_in   (dv_r1[j]),
      .n2_in   (dv_n2[j]),
      .r2_in   (dv_r2[j]),
      .tag_in  (dv_tag[j]),
      .d_out   (dv_d[j+1]),
      .n1_out  (dv_n1[j+1]),
      .r1_out  (dv_r1[j+1]),
      .n2_out  (dv_n2[j+1]),
      .r2_out  (dv_r2[j+1]),
      .tag_out (dv_tag[j+1])
    );
  end

  // sign and saturation
  function automatic logic [VALUE_W-1:0] sat_value(input logic [NQ-1:0] q, input logic neg);
    logic [QX-1:0]      qx;
    logic [VALUE_W-1:0] qv;
    qx = QX'(q);
    qv = VALUE_W'(qx);
    if (neg) begin
      sat_value = (qx > LIM) ? LIM[VALUE_W-1:0] : (~qv + 1'b1);
    end else begin
      sat_value = (qx > LIM - 1'b1) ? (LIM[VALUE_W-1:0] - 1'b1) : qv;
    end
  endfunction

  kind_t kind3;
  assign kind3 = kind_t'(dv_tag[NQ][3:2]);

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      root_kind <= kind3;
      if (kind3 == KIND_INVALID) begin
        first_value  <= '0;
        second_value <= '0;
      end else begin
        first_value  <= sat_value(dv_n1[NQ], dv_tag[NQ][1]);
        second_value <= sat_value(dv_n2[NQ], dv_tag[NQ][0]);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// one digit of a restoring square root, registered, with a pass-through tag
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt_cell #(
  parameter int NS = 33,
  parameter int TW = 8
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [2*NS-1:0]   rad_in,
  input  wire logic [NS+1:0]     rem_in,
  input  wire logic [NS-1:0]     root_in,
  input  wire logic [TW-1:0]     tag_in,
  output logic      [2*NS-1:0]   rad_out,
  output logic      [NS+1:0]     rem_out,
  output logic      [NS-1:0]     root_out,
  output logic      [TW-1:0]     tag_out
);

  logic [NS+3:0] rem_sh;
  logic [NS+3:0] trial;
  logic          ge;
  logic [NS+3:0] rem_diff;

  assign rem_sh   = {rem_in, rad_in[2*NS-1 -: 2]};
  assign trial    = {2'b00, root_in, 2'b01};
  assign ge       = (rem_sh >= trial);
  assign rem_diff = ge ? (rem_sh - trial) : rem_sh;

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[2*NS-3:0], 2'b00};
      rem_out  <= rem_diff[NS+1:0];
      root_out <= {root_in[NS-2:0], ge};
      tag_out  <= tag_in;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell
// one quotient bit of two restoring divisions sharing a divisor, registered
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div_cell #(
  parameter int NQ = 34,
  parameter int DW = 17,
  parameter int TW = 4
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] d_in,
  input  wire logic [NQ-1:0] n1_in,
  input  wire logic [DW-1:0] r1_in,
  input  wire logic [NQ-1:0] n2_in,
  input  wire logic [DW-1:0] r2_in,
  input  wire logic [TW-1:0] tag_in,
  output logic      [DW-1:0] d_out,
  output logic      [NQ-1:0] n1_out,
  output logic      [DW-1:0] r1_out,
  output logic      [NQ-1:0] n2_out,
  output logic      [DW-1:0] r2_out,
  output logic      [TW-1:0] tag_out
);

  logic [DW:0] sh1, sh2, dx, df1, df2;
  logic        ge1, ge2;

  assign dx  = {1'b0, d_in};
  assign sh1 = {r1_in, n1_in[NQ-1]};
  assign sh2 = {r2_in, n2_in[NQ-1]};
  assign ge1 = (sh1 >= dx);
  assign ge2 = (sh2 >= dx);
  assign df1 = ge1 ? (sh1 - dx) : sh1;
  assign df2 = ge2 ? (sh2 - dx) : sh2;

  always_ff @(posedge clk) begin
    if (en) begin
      d_out   <= d_in;
      n1_out  <= {n1_in[NQ-2:0], ge1};
      n2_out  <= {n2_in[NQ-2:0], ge2};
      r1_out  <= df1[DW-1:0];
      r2_out  <= df2[DW-1:0];
      tag_out <= tag_in;
    end
  end

endmodule

`default_nettype wire

### dv/quadratic_root_solver_test.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_test
// drives random and corner coefficient sets through the solver and checks
// every result against a bit-accurate predictor of the fixed-point roots
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver_test;
  import qrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int LATENCY = 2 * CW + 2 * FB + 7;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
  } coefs_t;

  typedef struct packed {
    kind_t kind;
    logic signed [VALUE_W-1:0] first;
    logic signed [VALUE_W-1:0] second;
  } roots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] coef_a = '0;
  logic signed [CW-1:0] coef_b = '0;
  logic signed [CW-1:0] coef_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] root_kind;
  logic signed [VALUE_W-1:0] first_value;
  logic signed [VALUE_W-1:0] second_value;

  coefs_t pending_sets[$];
  roots_t expected_roots[$];
  int errors = 0;
  longint cycles = 0;
  bit stimulus_done = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;

  quadratic_root_solver #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk, .rst, .in_valid, .in_ready, .coef_a, .coef_b, .coef_c,
    .out_valid, .out_ready, .root_kind, .first_value, .second_value
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] isqrt128(logic [127:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if ({64'd0, trial} * {64'd0, trial} <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [VALUE_W-1:0] clamp_value(logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (VALUE_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[VALUE_W-1:0];
    if (v < lo) return lo[VALUE_W-1:0];
    return v[VALUE_W-1:0];
  endfunction

  function automatic roots_t solve_roots(coefs_t s);
    roots_t r;
    logic signed [127:0] disc;
    logic signed [127:0] nb;
    logic signed [127:0] den;
    logic signed [127:0] root_s;
    logic [127:0] mag;
    disc = 128'(s.b) * 128'(s.b) - 128'sd4 * 128'(s.a) * 128'(s.c);
    mag = disc < 0 ? 128'(-disc) : 128'(disc);
    root_s = $signed({64'd0, isqrt128(mag << (2 * FB))});
    nb = -(128'(s.b) <<< FB);
    den = 128'sd2 * 128'(s.a);
    if (s.a == 0) begin
      r.kind = KIND_INVALID;
      r.first = '0;
      r.second = '0;
    end else if (disc > 0) begin
      r.kind = KIND_REAL;
      r.first = clamp_value((nb + root_s) / den);
      r.second = clamp_value((nb - root_s) / den);
    end else if (disc == 0) begin
      r.kind = KIND_REPEAT;
      r.first = clamp_value(nb / den);
      r.second = r.first;
    end else begin
      r.kind = KIND_COMPLEX;
      r.first = clamp_value(nb / den);
      r.second = clamp_value(root_s / den);
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_coef();
    int m;
    m = $urandom_range(0, 9);
    if (m < 4) return $signed(CW'($urandom));
    if (m < 8) return CW'(int'($urandom_range(0, 40)) - 20);
    return $signed(CW'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff));
  endfunction

  task automatic add_set(int a, int b, int c);
    coefs_t s;
    s.a = CW'(a);
    s.b = CW'(b);
    s.c = CW'(c);
    pending_sets.push_back(s);
  endtask

  initial begin
    coefs_t s;
    int k;
    add_set(0, 5, 7);
    add_set(0, 0, 0);
    add_set(1, -3, 2);
    add_set(1, 2, 1);
    add_set(1, 0, 1);
    add_set(-1, 0, -1);
    add_set(-2, 4, -2);
    add_set(-32768, -32768, -32768);
    add_set(-32768, 32767, 32767);
    add_set(32767, -32768, 32767);
    add_set(32767, 32767, -32768);
    add_set(-32768, 0, 32767);
    add_set(1, -32768, 0);
    add_set(1, 32767, 0);
    add_set(3, 0, 0);
    add_set(-1, 1, 0);
    add_set(2, 1, 1);
    add_set(-3, 1, -5);
    add_set(1, 1, -32768);
    add_set(-32768, 1, 1);
    for (int i = 0; i < 1400; i++) begin
      s.a = rand_coef();
      s.b = rand_coef();
      s.c = rand_coef();
      k = $urandom_range(0, 7);
      if (k == 0) s.c = CW'((s.b * s.b) / (4 * (s.a == 0 ? 1 : s.a)));
      pending_sets.push_back(s);
    end
    stimulus_done = 1;
  end

  // driver: bursts and gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 60);
        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      end
      if (burst_left > 0 && pending_sets.size() > 0) begin
        burst_left--;
        coef_a <= pending_sets[0].a;
        coef_b <= pending_sets[0].b;
        coef_c <= pending_sets[0].c;
        expected_roots.push_back(solve_roots(pending_sets.pop_front()));
        in_valid <= 1'b1;
      end else begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    roots_t want;
    cycles++;
    if (!rst && out_valid && out_ready) begin
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected result kind %0d", $time, root_kind);
        errors++;
      end else begin
        want = expected_roots.pop_front();
        if (root_kind !== want.kind) begin
          $display("%0t: root_kind expected %0d actual %0d", $time, want.kind, root_kind);
          errors++;
        end
        if (first_value !== want.first) begin
          $display("%0t: first_value expected %0d actual %0d", $time, want.first,
                   first_value);
          errors++;
        end
        if (second_value !== want.second) begin
          $display("%0t: second_value expected %0d actual %0d", $time, want.second,
                   second_value);
          errors++;
        end
      end
    end
    stall_phase = (stall_phase + 1) % 400;
    if (rst) out_ready <= 1'b0;
    else if (stall_phase < 100) out_ready <= 1'b1;
    else if (stall_phase < 120) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (!(stimulus_done && pending_sets.size() == 0 && expected_roots.size() == 0)
           && cycles < CYCLE_LIMIT)
      @(posedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      repeat (LATENCY + 10) @(posedge clk);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

`default_nettype wire
